/* hdl/i2cmbc_pkg.sv */
`timescale 1ns / 1ps
// Package for the I2C master byte controller: command codes, pin state type
// and the phase sequence tables. No dependencies.
package i2cmbc_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned PHASE_W     = 12;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned DATA_STEPS  = 2 * BYTE_BITS;
  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = PHASE_W'(125);

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_GETACK = 3'd4,
    CMD_ACK    = 3'd5,
    CMD_NAK    = 3'd6
  } cmd_t;

  // Pin state: SDA level, SDA drive enable, SCL level
  typedef struct packed {
    logic lvl;
    logic drv;
    logic scl;
  } pins_t;

  localparam pins_t PINS_RST = '{lvl: 1'b1, drv: 1'b0, scl: 1'b1};

  // Number of phases in a command; zero marks a code that starts nothing
  function automatic logic [STEP_W-1:0] seq_len(logic [CMD_W-1:0] code);
    logic [STEP_W-1:0] n;
    case (code)
      CMD_START:  n = STEP_W'(6);
      CMD_STOP:   n = STEP_W'(6);
      CMD_WRITE:  n = STEP_W'(DATA_STEPS + 1);
      CMD_READ:   n = STEP_W'(DATA_STEPS + 1);
      CMD_GETACK: n = STEP_W'(4);
      CMD_ACK:    n = STEP_W'(5);
      CMD_NAK:    n = STEP_W'(5);
      default:    n = '0;
    endcase
    return n;
  endfunction

  // Pin change applied on the first tick of a phase
  function automatic pins_t enter_phase(cmd_t code, logic [STEP_W-1:0] step,
                                        logic msb, pins_t cur);
    pins_t p;
    p = cur;
    case (code)
      CMD_START: begin
        case (step)
          STEP_W'(0): p.drv = 1'b1;
          STEP_W'(2): p.lvl = 1'b1;
          STEP_W'(3): p.scl = 1'b1;
          STEP_W'(4): p.lvl = 1'b0;
          STEP_W'(5): p.scl = 1'b0;
          default: ;
        endcase
      end
      CMD_STOP: begin
        case (step)
          STEP_W'(0): p.drv = 1'b1;
          STEP_W'(2): p.lvl = 1'b0;
          STEP_W'(3): p.scl = 1'b0;
          STEP_W'(4): p.scl = 1'b1;
          STEP_W'(5): p.lvl = 1'b1;
          default: ;
        endcase
      end
      CMD_WRITE: begin
        if (step >= STEP_W'(DATA_STEPS)) begin
          p.scl = 1'b0;
        end else if (!step[0]) begin
          p.drv = 1'b1;
          p.scl = 1'b0;
          p.lvl = msb;
        end else begin
          p.scl = 1'b1;
        end
      end
      CMD_READ: begin
        if (step >= STEP_W'(DATA_STEPS)) begin
          p.scl = 1'b0;
        end else if (!step[0]) begin
          p.drv = 1'b0;
          p.scl = 1'b0;
          p.lvl = 1'b1;
        end else begin
          p.scl = 1'b1;
        end
      end
      CMD_GETACK: begin
        if (step == STEP_W'(1) || step == STEP_W'(3)) begin
          p.scl = 1'b0;
        end else if (step == STEP_W'(2)) begin
          p.drv = 1'b0;
          p.scl = 1'b1;
        end
      end
      CMD_ACK, CMD_NAK: begin
        case (step)
          STEP_W'(0): p.drv = 1'b1;
          STEP_W'(1): p.scl = 1'b0;
          STEP_W'(2): p.lvl = (code == CMD_NAK);
          STEP_W'(3): p.scl = 1'b1;
          STEP_W'(4): p.scl = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

endpackage

/* hdl/i2cmbc_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the I2C master byte controller: one tick word per transfer.
// Uses i2cmbc_pkg for widths.
interface i2cmbc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd_valid;
  logic [i2cmbc_pkg::CMD_W-1:0]        mode;
  logic [i2cmbc_pkg::BYTE_BITS-1:0]    write_data;
  logic                                sda_in;

  modport source (output valid, output cmd_valid, output mode, output write_data,
                  output sda_in, input ready);
  modport sink (input valid, input cmd_valid, input mode, input write_data,
                input sda_in, output ready);
endinterface

/* hdl/i2cmbc_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the I2C master byte controller: pin levels and status per tick.
// Uses i2cmbc_pkg for widths.
interface i2cmbc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                scl_level;
  logic                                sda_drive;
  logic                                sda_level;
  logic                                busy_res;
  logic                                done_res;
  logic [i2cmbc_pkg::BYTE_BITS-1:0]    read_byte;
  logic                                ack_seen;

  modport source (output valid, output scl_level, output sda_drive, output sda_level,
                  output busy_res, output done_res, output read_byte, output ack_seen,
                  input ready);
  modport sink (input valid, input scl_level, input sda_drive, input sda_level,
                input busy_res, input done_res, input read_byte, input ack_seen,
                output ready);
endinterface

/* hdl/i2c_master_byte_controller_unit.sv */
`timescale 1ns / 1ps
// I2C master byte controller, top level.
// Uses i2cmbc_pkg, i2cmbc_in_if and i2cmbc_out_if.
//
// Usage:
//   in_ch carries one word per clock tick of the bus sequencer: a command
//   strobe (cmd_valid, mode, write_data) and the sampled SDA pin. A command
//   is taken only while no command is in progress; otherwise it is dropped.
//   out_ch returns exactly one word per input word: SCL level, SDA drive
//   enable and level, busy, done, the last read byte and the last ack bit.
//   cfg_we/cfg_wdata set the ticks per half-bit phase (reset 125, zero acts
//   as one); write it only while idle.
// Timing:
//   One input word is accepted per cycle while out_ch is not stalled; its
//   result word appears in the output register on the next cycle.
//   The whole tick update is one pass of logic from state and input word to
//   the state and output registers.
// Reset and stall:
//   Reset returns the sequencer to idle with SCL high and SDA released, and
//   empties the output register. When the receiver holds out_ch.ready low,
//   the pending result is held and in_ch.ready drops until it is taken.
module i2c_master_byte_controller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cmbc_in_if.sink                           in_ch,
  i2cmbc_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [i2cmbc_pkg::PHASE_W-1:0]      cfg_wdata
);

  localparam int unsigned PW = i2cmbc_pkg::PHASE_W;
  localparam int unsigned SW = i2cmbc_pkg::STEP_W;
  localparam int unsigned BB = i2cmbc_pkg::BYTE_BITS;

  // State registers
  logic [PW-1:0]          phase_ticks_r;
  logic [PW-1:0]          phase_cnt_r,  phase_cnt_nxt;
  logic [SW-1:0]          step_r,       step_nxt;
  i2cmbc_pkg::cmd_t       cmd_r,        cmd_nxt;
  logic                   busy_r,       busy_nxt;
  logic [BB-1:0]          shift_r,      shift_nxt;
  logic [BB-1:0]          rx_byte_r,    rx_byte_nxt;
  logic                   ack_r,        ack_nxt;
  i2cmbc_pkg::pins_t      pins_r,       pins_nxt;
  logic                   done_nxt;

  // Output register
  logic                   out_valid_r;
  logic                   out_done_r;

  logic                   accept;
  logic                   launch;
  logic [PW-1:0]          len;
  logic [PW:0]            cnt_inc;
  logic [SW-1:0]          step_inc;

  // Take a word whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign len = (phase_ticks_r == '0) ? PW'(1) : phase_ticks_r;

  // One tick of the bus sequencer
  always_comb begin
    launch        = !busy_r && in_ch.cmd_valid &&
                    (i2cmbc_pkg::seq_len(in_ch.mode) != '0);
    cmd_nxt       = launch ? i2cmbc_pkg::cmd_t'(in_ch.mode) : cmd_r;
    step_nxt      = launch ? '0 : step_r;
    phase_cnt_nxt = launch ? '0 : phase_cnt_r;
    busy_nxt      = launch || busy_r;
    shift_nxt     = shift_r;
    if (launch) begin
      shift_nxt = (cmd_nxt == i2cmbc_pkg::CMD_WRITE) ? in_ch.write_data : '0;
    end
    rx_byte_nxt   = rx_byte_r;
    ack_nxt       = ack_r;
    pins_nxt      = pins_r;
    done_nxt      = 1'b0;
    cnt_inc       = '0;
    step_inc      = '0;

    if (busy_nxt) begin
      // apply the pin change on the first tick of a phase
      if (phase_cnt_nxt == '0) begin
        pins_nxt = i2cmbc_pkg::enter_phase(cmd_nxt, step_nxt, shift_nxt[BB-1], pins_r);
      end
      cnt_inc = {1'b0, phase_cnt_nxt} + (PW+1)'(1);
      if (cnt_inc >= {1'b0, len}) begin
        // end of phase: shift or sample, then advance the step
        if (step_nxt < SW'(i2cmbc_pkg::DATA_STEPS) && step_nxt[0]) begin
          if (cmd_nxt == i2cmbc_pkg::CMD_WRITE) begin
            shift_nxt = {shift_nxt[BB-2:0], 1'b0};
          end else if (cmd_nxt == i2cmbc_pkg::CMD_READ) begin
            shift_nxt = {shift_nxt[BB-2:0], in_ch.sda_in};
          end
        end
        if (cmd_nxt == i2cmbc_pkg::CMD_GETACK && step_nxt == SW'(2)) begin
          ack_nxt = in_ch.sda_in;
        end
        phase_cnt_nxt = '0;
        step_inc      = step_nxt + SW'(1);
        step_nxt      = step_inc;
        if (step_inc >= i2cmbc_pkg::seq_len(cmd_nxt)) begin
          if (cmd_nxt == i2cmbc_pkg::CMD_READ) begin
            rx_byte_nxt = shift_nxt;
          end
          busy_nxt = 1'b0;
          step_nxt = '0;
          done_nxt = 1'b1;
        end
      end else begin
        phase_cnt_nxt = cnt_inc[PW-1:0];
      end
    end
  end

  // Hold the phase length; it must be written only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbc_pkg::PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  // Advance the sequencer state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_cnt_r <= '0;
      step_r      <= '0;
      cmd_r       <= i2cmbc_pkg::CMD_START;
      busy_r      <= 1'b0;
      shift_r     <= '0;
      rx_byte_r   <= '0;
      ack_r       <= 1'b0;
      pins_r      <= i2cmbc_pkg::PINS_RST;
      out_done_r  <= 1'b0;
    end else if (accept) begin
      phase_cnt_r <= phase_cnt_nxt;
      step_r      <= step_nxt;
      cmd_r       <= cmd_nxt;
      busy_r      <= busy_nxt;
      shift_r     <= shift_nxt;
      rx_byte_r   <= rx_byte_nxt;
      ack_r       <= ack_nxt;
      pins_r      <= pins_nxt;
      out_done_r  <= done_nxt;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Drive the result word from the registered state
  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = pins_r.scl;
  assign out_ch.sda_drive = pins_r.drv;
  assign out_ch.sda_level = !pins_r.drv || pins_r.lvl;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = out_done_r;
  assign out_ch.read_byte = rx_byte_r;
  assign out_ch.ack_seen  = ack_r;

endmodule

/* sim/i2cmbc_bus_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the I2C master byte controller: predicts each result word from the
// accepted input words and the phase length register. Uses i2cmbc_pkg and both channel interfaces.
module i2cmbc_bus_checker
  import i2cmbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  i2cmbc_in_if                 in_mon,
  i2cmbc_out_if                out_mon,
  input  logic                 cfg_we,
  input  logic [PHASE_W-1:0]   cfg_wdata,
  input  logic                 end_of_run,
  output int unsigned          fail_count
);

  typedef struct packed {
    logic       scl;
    logic       drv;
    logic       lvl;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       ack;
  } bus_word_t;

  // Sequencer copy
  logic [PHASE_W-1:0] tick_len_reg;
  logic [PHASE_W:0]   tick_cnt;
  logic [STEP_W-1:0]  step_no;
  logic [CMD_W-1:0]   cur_cmd;
  logic               seq_busy;
  logic [7:0]         shifter;
  logic [7:0]         rx_byte;
  logic               ack_flag;
  pins_t              pins;
  bit                 end_seen;

  bus_word_t expected_words[$];

  function automatic int unsigned phases_of(logic [CMD_W-1:0] code);
    case (code)
      CMD_START, CMD_STOP:  return 6;
      CMD_WRITE, CMD_READ:  return 2 * BYTE_BITS + 1;
      CMD_GETACK:           return 4;
      CMD_ACK, CMD_NAK:     return 5;
      default:              return 0;
    endcase
  endfunction

  // Pin levels after the change made on entry to phase s of a command
  function automatic pins_t phase_entry_pins(logic [CMD_W-1:0] code, logic [STEP_W-1:0] s,
                                             logic msb, pins_t cur);
    pins_t p;
    p = cur;
    if (code == CMD_START) begin
      if (s == 0) p.drv = 1'b1;
      else if (s == 2) p.lvl = 1'b1;
      else if (s == 3) p.scl = 1'b1;
      else if (s == 4) p.lvl = 1'b0;
      else if (s == 5) p.scl = 1'b0;
    end else if (code == CMD_STOP) begin
      if (s == 0) p.drv = 1'b1;
      else if (s == 2) p.lvl = 1'b0;
      else if (s == 3) p.scl = 1'b0;
      else if (s == 4) p.scl = 1'b1;
      else if (s == 5) p.lvl = 1'b1;
    end else if (code == CMD_WRITE || code == CMD_READ) begin
      if (s >= 2 * BYTE_BITS) begin
        p.scl = 1'b0;
      end else if (s[0]) begin
        p.scl = 1'b1;
      end else begin
        // Low half of a bit: write drives the data bit, read lets go of SDA
        p.scl = 1'b0;
        p.drv = (code == CMD_WRITE);
        p.lvl = (code == CMD_WRITE) ? msb : 1'b1;
      end
    end else if (code == CMD_GETACK) begin
      if (s == 1 || s == 3) begin
        p.scl = 1'b0;
      end else if (s == 2) begin
        p.drv = 1'b0;
        p.scl = 1'b1;
      end
    end else if (code == CMD_ACK || code == CMD_NAK) begin
      if (s == 0) p.drv = 1'b1;
      else if (s == 1 || s == 4) p.scl = 1'b0;
      else if (s == 2) p.lvl = (code == CMD_NAK);
      else if (s == 3) p.scl = 1'b1;
    end
    return p;
  endfunction

  // Advance the sequencer copy by one tick and form the word it should emit
  task automatic predict_tick(input logic cv, input logic [CMD_W-1:0] m,
                              input logic [7:0] wd, input logic sda, output bus_word_t w);
    int unsigned len;
    logic        fin;
    len = (tick_len_reg == 0) ? 1 : tick_len_reg;
    fin = 1'b0;
    if (!seq_busy && cv && phases_of(m) != 0) begin
      cur_cmd  = m;
      step_no  = '0;
      tick_cnt = '0;
      seq_busy = 1'b1;
      shifter  = (m == CMD_WRITE) ? wd : 8'h00;
    end
    if (seq_busy) begin
      if (tick_cnt == 0) pins = phase_entry_pins(cur_cmd, step_no, shifter[7], pins);
      tick_cnt = tick_cnt + 1;
      if (tick_cnt >= len) begin
        tick_cnt = '0;
        // Sample or shift on the last tick of the phase
        if (cur_cmd == CMD_WRITE && step_no < 2 * BYTE_BITS && step_no[0])
          shifter = {shifter[6:0], 1'b0};
        else if (cur_cmd == CMD_READ && step_no < 2 * BYTE_BITS && step_no[0])
          shifter = {shifter[6:0], sda};
        else if (cur_cmd == CMD_GETACK && step_no == 2)
          ack_flag = sda;
        step_no = step_no + 1'b1;
        if (step_no >= phases_of(cur_cmd)) begin
          if (cur_cmd == CMD_READ) rx_byte = shifter;
          seq_busy = 1'b0;
          step_no  = '0;
          fin      = 1'b1;
        end
      end
    end
    w = '{scl: pins.scl, drv: pins.drv, lvl: (!pins.drv || pins.lvl), busy: seq_busy,
          done: fin, rbyte: rx_byte, ack: ack_flag};
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    bus_word_t want_w;
    bus_word_t got_w;
    bus_word_t next_w;
    if (!rst_n) begin
      tick_len_reg = PHASE_TICKS_RST;
      tick_cnt     = '0;
      step_no      = '0;
      cur_cmd      = CMD_START;
      seq_busy     = 1'b0;
      shifter      = 8'h00;
      rx_byte      = 8'h00;
      ack_flag     = 1'b0;
      pins         = PINS_RST;
      end_seen     = 1'b0;
      fail_count   = 0;
      expected_words.delete();
    end else begin
      // Compare a taken result word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got_w = '{scl: out_mon.scl_level, drv: out_mon.sda_drive, lvl: out_mon.sda_level,
                  busy: out_mon.busy_res, done: out_mon.done_res,
                  rbyte: out_mon.read_byte, ack: out_mon.ack_seen};
        if (expected_words.size() == 0) begin
          $error("result word with no prediction pending");
          fail_count++;
        end else begin
          want_w = expected_words.pop_front();
          check_field("scl_level", want_w.scl, got_w.scl);
          check_field("sda_drive", want_w.drv, got_w.drv);
          check_field("sda_level", want_w.lvl, got_w.lvl);
          check_field("busy_res", want_w.busy, got_w.busy);
          check_field("done_res", want_w.done, got_w.done);
          check_field("read_byte", want_w.rbyte, got_w.rbyte);
          check_field("ack_seen", want_w.ack, got_w.ack);
        end
      end
      // Predict from a taken input word
      if (in_mon.valid && in_mon.ready) begin
        predict_tick(in_mon.cmd_valid, in_mon.mode, in_mon.write_data, in_mon.sda_in, next_w);
        expected_words.push_back(next_w);
      end
      if (cfg_we) tick_len_reg = cfg_wdata;
      // Anything still predicted once the run is over never arrived
      if (end_of_run && !end_seen) begin
        end_seen = 1'b1;
        if (expected_words.size() != 0) begin
          $error("%0d predicted result words never arrived", expected_words.size());
          fail_count++;
        end
      end
    end
  end

endmodule

/* sim/tb_i2c_master_byte_controller_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the I2C master byte controller: clock, reset, stimulus and verdict.
// Uses i2cmbc_pkg, the channel interfaces, the block and i2cmbc_bus_checker.
module tb_i2c_master_byte_controller_unit;
  import i2cmbc_pkg::*;

  localparam logic [CMD_W-1:0] MODE_NONE = 3'd7;
  localparam int SDA_LOW    = 0;
  localparam int SDA_HI     = 1;
  localparam int SDA_RANDOM = 2;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [PHASE_W-1:0] cfg_wdata;
  logic               end_of_run;
  int unsigned        fail_count;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_req = 0;
  int          n_in = 0;
  int          n_out = 0;
  logic        last_busy = 1'b1;
  int unsigned cur_ticks = PHASE_TICKS_RST;

  i2cmbc_in_if  in_ch ();
  i2cmbc_out_if out_ch ();

  i2c_master_byte_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2cmbc_bus_checker bus_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .end_of_run (end_of_run),
    .fail_count (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count taken result words and keep the latest busy flag
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out     <= n_out + 1;
      last_busy <= out_ch.busy_res;
    end
  end

  // Result side: random hold-off, plus a long stall whenever one is requested
  initial begin
    int hold_left;
    int stall_seen;
    hold_left  = 0;
    stall_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic int unsigned cmd_phases(logic [CMD_W-1:0] m);
    case (m)
      CMD_START, CMD_STOP:  return 6;
      CMD_WRITE, CMD_READ:  return 2 * BYTE_BITS + 1;
      CMD_GETACK:           return 4;
      CMD_ACK, CMD_NAK:     return 5;
      default:              return 0;
    endcase
  endfunction

  // Offer one tick word, with random gaps, and hold it until taken
  task automatic send_tick(input logic cv, input logic [CMD_W-1:0] m, input logic [7:0] wd,
                           input logic sda);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= cv;
    in_ch.mode       <= m;
    in_ch.write_data <= wd;
    in_ch.sda_in     <= sda;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_in++;
  endtask

  // Feed idle ticks until a result word sent after them shows the sequencer idle,
  // then drop valid and let every result come back
  task automatic settle_idle(input int sda_pick);
    int   first_idx;
    logic sda;
    first_idx = n_in;
    while (!(n_out > first_idx && !last_busy)) begin
      sda = (sda_pick == SDA_RANDOM) ? 1'($urandom) : 1'(sda_pick);
      send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), sda);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (n_out == n_in);
  endtask

  task automatic run_cmd(input logic [CMD_W-1:0] m, input logic [7:0] wd, input int sda_pick);
    send_tick(1'b1, m, wd, (sda_pick == SDA_RANDOM) ? 1'($urandom) : 1'(sda_pick));
    settle_idle(sda_pick);
  endtask

  task automatic set_phase_ticks(input logic [PHASE_W-1:0] v);
    settle_idle(SDA_RANDOM);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_ticks = v;
  endtask

  // Command word followed by idle ticks for roughly its length; the next command
  // sometimes lands while the sequencer is still busy, and some gap ticks carry stray commands
  task automatic issue_cmd(input logic [CMD_W-1:0] m, input logic [7:0] wd);
    int unsigned len;
    int          gap;
    len = (cur_ticks == 0) ? 1 : cur_ticks;
    gap = int'(cmd_phases(m) * len) + int'($urandom_range(0, 7)) - 2;
    send_tick(1'b1, m, wd, 1'($urandom));
    for (int i = 0; i < gap; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      else
        send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
    end
  endtask

  // Mostly well-formed bus transfers with random bytes and SDA, some stray commands
  task automatic random_traffic(input int n_words);
    int stop_at;
    int n_bytes;
    stop_at = n_in + n_words;
    while (n_in < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_cmd(3'($urandom_range(0, 7)), 8'($urandom));
      end else begin
        issue_cmd(CMD_START, 8'($urandom));
        n_bytes = $urandom_range(1, 3);
        repeat (n_bytes) begin
          if ($urandom_range(0, 1) == 1) begin
            issue_cmd(CMD_WRITE, 8'($urandom));
            issue_cmd(CMD_GETACK, 8'($urandom));
          end else begin
            issue_cmd(CMD_READ, 8'($urandom));
            issue_cmd(($urandom_range(0, 1) == 1) ? CMD_ACK : CMD_NAK, 8'($urandom));
          end
        end
        // Leave some transfers open so that the next start is a repeated start
        if ($urandom_range(0, 3) != 0) issue_cmd(CMD_STOP, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    end_of_run       = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd_valid  = 1'b0;
    in_ch.mode       = CMD_START;
    in_ch.write_data = 8'h00;
    in_ch.sda_in     = 1'b1;
    send_idle_pct    = 38;
    recv_idle_pct    = 79;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one get ack at the reset phase length, NAK on the line
    run_cmd(CMD_GETACK, 8'h00, SDA_HI);
    set_phase_ticks(12'd1);
    run_cmd(CMD_START, 8'h00, SDA_RANDOM);
    run_cmd(CMD_WRITE, 8'hFF, SDA_HI);
    run_cmd(CMD_GETACK, 8'h00, SDA_LOW);
    run_cmd(CMD_WRITE, 8'h00, SDA_LOW);
    run_cmd(CMD_GETACK, 8'hFF, SDA_HI);
    run_cmd(CMD_READ, 8'hFF, SDA_HI);
    run_cmd(CMD_ACK, 8'h00, SDA_RANDOM);
    run_cmd(CMD_READ, 8'h00, SDA_LOW);
    run_cmd(CMD_NAK, 8'hFF, SDA_RANDOM);
    run_cmd(CMD_READ, 8'($urandom), SDA_RANDOM);
    run_cmd(CMD_STOP, 8'h00, SDA_RANDOM);
    // Unused mode code starts nothing
    run_cmd(MODE_NONE, 8'hA5, SDA_RANDOM);
    // A command offered while busy is dropped
    send_tick(1'b1, CMD_WRITE, 8'h96, 1'b0);
    send_tick(1'b1, CMD_READ, 8'h69, 1'b1);
    settle_idle(SDA_RANDOM);
    // Zero phase length behaves as one tick
    set_phase_ticks(12'd0);
    run_cmd(CMD_START, 8'h00, SDA_RANDOM);
    run_cmd(CMD_WRITE, 8'h5A, SDA_RANDOM);
    run_cmd(CMD_STOP, 8'h00, SDA_RANDOM);

    // Random, sender light and receiver heavy idling
    set_phase_ticks(12'd2);
    random_traffic(40);
    set_phase_ticks(12'd1);
    random_traffic(40);

    // Random, idling swapped
    send_idle_pct = 79;
    recv_idle_pct = 38;
    set_phase_ticks(12'd3);
    random_traffic(40);
    set_phase_ticks(12'd0);
    random_traffic(40);

    // Random, no idling; long receiver stall early on to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_phase_ticks(12'd1);
    stall_req++;
    random_traffic(40);
    set_phase_ticks(12'd2);
    random_traffic(40);

    // Drain and give the verdict
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (n_out == n_in);
    repeat (4) @(posedge clk);
    @(negedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_800_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
hdl/i2cmbc_pkg.sv
hdl/i2cmbc_in_if.sv
hdl/i2cmbc_out_if.sv
hdl/i2c_master_byte_controller_unit.sv
sim/i2cmbc_bus_checker.sv
sim/tb_i2c_master_byte_controller_unit.sv
